// ----- sv/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the trend test statistic tracker
// Holds the word carried from the front end to the back end, the register
// indexes and the default sizes.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int COVARIATES_DEF = 8;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_TRIM_WIDTH = 2'd0;
	localparam logic [1:0] CFG_NUM_STEPS  = 2'd1;

	localparam logic [9:0]  TRIM_RESET  = 10'd0;
	localparam logic [10:0] STEPS_RESET = 11'd1024;

	localparam logic [31:0] MAX32  = 32'hFFFF_FFFF;
	localparam logic [47:0] MAX48  = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_SAT = 32'h8000_0000;

	// classified sample handed to the back end (covariate travels beside it)
	typedef struct packed {
		logic               restart;
		logic               weighted;
		logic               inwin;
		logic signed [31:0] cu;
		logic signed [33:0] d;
		logic [31:0]        var_v;
		logic [31:0]        tv;
		logic [31:0]        dt;
	} tts_item_t;

endpackage

// ----- sv/tts_queue.sv -----
// ----------------------------------------------------------------------------
// tts_queue: two-entry word queue between front and back end
// Plain FIFO with registered storage; full and empty flags from a count.
// ----------------------------------------------------------------------------
module tts_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic         nonempty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rdata    = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/tts_front.sv -----
// ----------------------------------------------------------------------------
// tts_front: input side of the tracker
// Holds the registers, accepts samples, forms the linear trend, the raw
// deviation and the window flag, and pushes a classified word to the queue.
// ----------------------------------------------------------------------------
module tts_front #(
	parameter int COVARIATES = tts_pkg::COVARIATES_DEF,
	parameter int CW = (COVARIATES > 1) ? $clog2(COVARIATES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          covariate_index,
	input  logic [9:0]          step_index,
	input  logic                restart,
	input  logic signed [31:0]  cumulative_value,
	input  logic signed [31:0]  final_value,
	input  logic [31:0]         variance,
	input  logic [31:0]         trend_variance,
	input  logic [16:0]         time_fraction,
	input  logic [31:0]         step_width,
	output logic                push,
	input  logic                q_full,
	output tts_pkg::tts_item_t  item,
	output logic [CW-1:0]       cov
);
	logic [9:0]  trim_q;
	logic [10:0] steps_q;

	logic               v_s1;
	logic [CW-1:0]      cov_s1;
	logic               restart_s1, fneg_s1, weighted_s1, inwin_s1;
	logic signed [31:0] cu_s1;
	logic [48:0]        prod_s1;
	logic [31:0]        var_s1, tv_s1, dt_s1;

	logic        accept;
	logic [31:0] fmag;
	logic [6:0]  cmod;
	logic signed [11:0] lim, sx;
	logic        inwin;
	logic [32:0] tmag;
	logic signed [33:0] trend;

	assign push     = v_s1 && !q_full;
	assign in_ready = !v_s1 || !q_full;
	assign accept   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q  <= tts_pkg::TRIM_RESET;
			steps_q <= tts_pkg::STEPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tts_pkg::CFG_TRIM_WIDTH: trim_q  <= cfg_data[9:0];
				tts_pkg::CFG_NUM_STEPS:  steps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// covariate index folded into range, magnitude of final value, window
	always_comb begin
		cmod = {4'd0, covariate_index};
		for (int i = 0; i < 8; i++) begin
			if (cmod >= 7'(COVARIATES)) cmod = cmod - 7'(COVARIATES);
		end
		fmag  = final_value[31] ? (~final_value + 32'd1) : final_value;
		sx    = signed'({2'b00, step_index});
		lim   = signed'({1'b0, steps_q}) - signed'({2'b00, trim_q});
		inwin = (step_index > trim_q) && (sx < lim);
	end

	// stage 1: trend product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (accept) v_s1 <= 1'b1;
		else if (push) v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cov_s1      <= cmod[CW-1:0];
			restart_s1  <= restart;
			fneg_s1     <= final_value[31];
			cu_s1       <= cumulative_value;
			prod_s1     <= fmag * time_fraction;
			var_s1      <= variance;
			tv_s1       <= trend_variance;
			dt_s1       <= step_width;
			weighted_s1 <= (trim_q != 10'd0);
			inwin_s1    <= inwin;
		end
	end

	// raw deviation from the trend, exact in 34 bits
	always_comb begin
		tmag  = prod_s1[48:16];
		trend = fneg_s1 ? -signed'({1'b0, tmag}) : signed'({1'b0, tmag});
		item.restart  = restart_s1;
		item.weighted = weighted_s1;
		item.inwin    = inwin_s1;
		item.cu       = cu_s1;
		item.d        = {{2{cu_s1[31]}}, cu_s1} - trend;
		item.var_v    = var_s1;
		item.tv       = tv_s1;
		item.dt       = dt_s1;
		cov           = cov_s1;
	end

endmodule

// ----- sv/tts_back.sv -----
// ----------------------------------------------------------------------------
// tts_back: arithmetic sequencer and statistics stores
// One shared square root unit (two bits a cycle), one shared divider (one
// quotient bit a cycle) and a 16-bit-slice multiplier work each word in turn;
// the result goes to an output register.
// ----------------------------------------------------------------------------
module tts_back #(
	parameter int COVARIATES = tts_pkg::COVARIATES_DEF,
	parameter int CW = (COVARIATES > 1) ? $clog2(COVARIATES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_nonempty,
	output logic                pop,
	input  tts_pkg::tts_item_t  q_item,
	input  logic [CW-1:0]       q_cov,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  deviation,
	output logic [31:0]         sup_standardized,
	output logic [31:0]         sup_deviation,
	output logic [47:0]         integral_deviation
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ1  = 4'd1;
	localparam logic [3:0] S_DV1  = 4'd2;
	localparam logic [3:0] S_SQ2  = 4'd3;
	localparam logic [3:0] S_DV2  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DV3  = 4'd6;
	localparam logic [3:0] S_UPD  = 4'd7;

	logic [3:0] st_q;
	logic [6:0] cnt_q;

	tts_pkg::tts_item_t it_q;
	logic [CW-1:0]      cov_q;

	// square root unit
	logic [47:0] sx_q;
	logic [25:0] srem_q;
	logic [23:0] sroot_q;
	// divider
	logic [48:0] drem_q;
	logic [47:0] dlo_q, dvs_q, dq_q;
	// multiplier
	logic [97:0] mp_q;
	logic [65:0] ma_q;
	logic [47:0] mb_q;
	logic        mph_q;

	logic [31:0]        stdv_q;
	logic signed [31:0] dev_q;
	logic [47:0]        incr_q;

	// statistics stores with per-entry valid bits
	logic [31:0] mst_mem [COVARIATES];
	logic [31:0] mdv_mem [COVARIATES];
	logic [47:0] int_mem [COVARIATES];
	logic [COVARIATES-1:0] vld_q;
	logic [31:0] mst_rd_q, mdv_rd_q;
	logic [47:0] int_rd_q;

	// datapath helpers
	logic [27:0] s_rem2, s_trial;
	logic [49:0] d_t;
	logic [81:0] m_prod;
	logic [33:0] ad_full;
	logic [32:0] ad;
	logic [31:0] acu;
	logic [31:0] dsat;
	logic [31:0] q31;
	logic [31:0] adev;
	logic [31:0] old_mst, old_mdv, new_mst, new_mdv;
	logic [47:0] old_int, new_int;
	logic [48:0] int_sum;
	logic        upd;
	logic [31:0] dvbase;

	always_comb begin
		s_rem2  = {srem_q, sx_q[47:46]};
		s_trial = {2'b00, sroot_q, 2'b01};
		d_t     = {drem_q, dlo_q[47]};
		m_prod  = ma_q * mb_q[47:32];
		ad_full = it_q.d[33] ? (~it_q.d + 34'sd1) : it_q.d;
		ad      = ad_full[32:0];
		acu     = it_q.cu[31] ? (~it_q.cu + 32'sd1) : it_q.cu;
		if (it_q.d[33:31] == 3'b000 || it_q.d[33:31] == 3'b111) dsat = it_q.d[31:0];
		else if (it_q.d[33]) dsat = tts_pkg::NEG_SAT;
		else dsat = tts_pkg::POS_SAT;
		q31     = {1'b0, dq_q[30:0]};
		dvbase  = it_q.tv;
	end

	assign pop = (st_q == S_IDLE) && q_nonempty;
	assign upd = (st_q == S_UPD) && (!out_valid || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cnt_q <= 7'd0;
			mph_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (q_nonempty) begin
						st_q  <= S_SQ1;
						cnt_q <= 7'd24;
					end
				end
				S_SQ1, S_SQ2, S_DV1, S_DV2, S_DV3: begin
					if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
					else begin
						st_q <= S_UPD;
						case (st_q)
							S_SQ1: begin
								if (sroot_q != 24'd0 && {8'd0, acu[31:16]} < sroot_q) begin
									st_q <= S_DV1; cnt_q <= 7'd32;
								end else if (it_q.weighted && it_q.inwin) begin
									st_q <= S_SQ2; cnt_q <= 7'd24;
								end else if (it_q.inwin && ad != 33'd0 && it_q.dt != 32'd0) begin
									st_q <= S_MUL; cnt_q <= 7'd3; mph_q <= 1'b0;
								end
							end
							S_DV1: begin
								if (it_q.weighted && it_q.inwin) begin
									st_q <= S_SQ2; cnt_q <= 7'd24;
								end else if (it_q.inwin && ad != 33'd0 && it_q.dt != 32'd0) begin
									st_q <= S_MUL; cnt_q <= 7'd3; mph_q <= 1'b0;
								end
							end
							S_SQ2: begin
								if (sroot_q != 24'd0 && {6'd0, ad[32:15]} < sroot_q) begin
									st_q <= S_DV2; cnt_q <= 7'd31;
								end else if (ad != 33'd0 && it_q.dt != 32'd0
										&& it_q.tv != 32'd0) begin
									st_q <= S_MUL; cnt_q <= 7'd3; mph_q <= 1'b0;
								end
							end
							S_DV2: begin
								if (ad != 33'd0 && it_q.dt != 32'd0 && it_q.tv != 32'd0) begin
									st_q <= S_MUL; cnt_q <= 7'd3; mph_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
					else if (!mph_q) begin
						mph_q <= 1'b1; cnt_q <= 7'd2;
					end else if (it_q.weighted && mp_q[97:48] < {2'b00, dvbase, 16'd0}) begin
						st_q <= S_DV3; cnt_q <= 7'd48;
					end else st_q <= S_UPD;
				end
				S_UPD: if (upd) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (q_nonempty) begin
					it_q    <= q_item;
					cov_q   <= q_cov;
					sx_q    <= {q_item.var_v, 16'd0};
					srem_q  <= 26'd0;
					sroot_q <= 24'd0;
					incr_q  <= 48'd0;
					dev_q   <= 32'sd0;
				end
			end
			S_SQ1, S_SQ2: begin
				if (cnt_q != 7'd0) begin
					sx_q <= {sx_q[45:0], 2'b00};
					if (s_rem2 >= s_trial) begin
						srem_q  <= 26'(s_rem2 - s_trial);
						sroot_q <= {sroot_q[22:0], 1'b1};
					end else begin
						srem_q  <= s_rem2[25:0];
						sroot_q <= {sroot_q[22:0], 1'b0};
					end
				end else if (st_q == S_SQ1) begin
					// standardized value: special, saturated or divide
					if (sroot_q == 24'd0) stdv_q <= (acu != 32'd0) ? tts_pkg::MAX32 : 32'd0;
					else stdv_q <= tts_pkg::MAX32;
					drem_q <= {33'd0, acu[31:16]};
					dlo_q  <= {acu[15:0], 32'd0};
					dvs_q  <= {24'd0, sroot_q};
					dq_q   <= 48'd0;
					if (!it_q.weighted) dev_q <= signed'(dsat);
					sx_q    <= {it_q.tv, 16'd0};
					srem_q  <= 26'd0;
					sroot_q <= 24'd0;
				end else begin
					// scaled deviation: special, saturated or divide
					if (it_q.d == 34'sd0) dev_q <= 32'sd0;
					else if (it_q.d[33]) dev_q <= signed'(tts_pkg::NEG_SAT);
					else dev_q <= signed'(tts_pkg::POS_SAT);
					drem_q <= {31'd0, ad[32:15]};
					dlo_q  <= {ad[14:0], 33'd0};
					dvs_q  <= {24'd0, sroot_q};
					dq_q   <= 48'd0;
					if (it_q.tv == 32'd0 && ad != 33'd0 && it_q.dt != 32'd0)
						incr_q <= tts_pkg::MAX48;
				end
				mp_q <= 98'd0;
				ma_q <= {33'd0, ad};
				mb_q <= {15'd0, ad};
			end
			S_DV1, S_DV2, S_DV3: begin
				if (cnt_q != 7'd0) begin
					dlo_q <= {dlo_q[46:0], 1'b0};
					if (d_t >= {2'b00, dvs_q}) begin
						drem_q <= 49'(d_t - {2'b00, dvs_q});
						dq_q   <= {dq_q[46:0], 1'b1};
					end else begin
						drem_q <= d_t[48:0];
						dq_q   <= {dq_q[46:0], 1'b0};
					end
				end else begin
					case (st_q)
						S_DV1:   stdv_q <= dq_q[31:0];
						S_DV2:   dev_q  <= it_q.d[33] ? -signed'(q31) : signed'(q31);
						default: incr_q <= dq_q;
					endcase
				end
				if (cnt_q == 7'd0 && st_q == S_DV1) begin
					sx_q    <= {it_q.tv, 16'd0};
					srem_q  <= 26'd0;
					sroot_q <= 24'd0;
					if (!it_q.weighted) dev_q <= signed'(dsat);
				end
				if (cnt_q == 7'd0 && st_q != S_DV3) begin
					mp_q <= 98'd0;
					ma_q <= {33'd0, ad};
					mb_q <= {15'd0, ad};
				end
			end
			S_MUL: begin
				if (cnt_q != 7'd0) begin
					mp_q <= {mp_q[81:0], 16'd0} + {16'd0, m_prod};
					mb_q <= {mb_q[31:0], 16'd0};
				end else if (!mph_q) begin
					ma_q <= mp_q[65:0];
					mp_q <= 98'd0;
					mb_q <= {it_q.dt, 16'd0};
				end else begin
					// unweighted: divide by 2^32; weighted: divider or saturate
					if (!it_q.weighted)
						incr_q <= (mp_q[97:80] != 18'd0) ? tts_pkg::MAX48 : mp_q[79:32];
					else incr_q <= tts_pkg::MAX48;
					drem_q <= mp_q[96:48];
					dlo_q  <= mp_q[47:0];
					dvs_q  <= {dvbase, 16'd0};
					dq_q   <= 48'd0;
				end
			end
			default: ;
		endcase
	end

	// statistics update
	always_comb begin
		old_mst = (vld_q[cov_q] && !it_q.restart) ? mst_rd_q : 32'd0;
		old_mdv = (vld_q[cov_q] && !it_q.restart) ? mdv_rd_q : 32'd0;
		old_int = (vld_q[cov_q] && !it_q.restart) ? int_rd_q : 48'd0;
		adev    = dev_q[31] ? (~dev_q + 32'sd1) : dev_q;
		new_mst = (stdv_q > old_mst) ? stdv_q : old_mst;
		new_mdv = (adev > old_mdv) ? adev : old_mdv;
		int_sum = {1'b0, old_int} + {1'b0, incr_q};
		if (!it_q.inwin) new_int = old_int;
		else new_int = int_sum[48] ? tts_pkg::MAX48 : int_sum[47:0];
	end

	always_ff @(posedge clk) begin
		mst_rd_q <= mst_mem[cov_q];
		mdv_rd_q <= mdv_mem[cov_q];
		int_rd_q <= int_mem[cov_q];
		if (upd) begin
			mst_mem[cov_q] <= new_mst;
			mdv_mem[cov_q] <= new_mdv;
			int_mem[cov_q] <= new_int;
			deviation          <= dev_q;
			sup_standardized   <= new_mst;
			sup_deviation      <= new_mdv;
			integral_deviation <= new_int;
		end
	end

	// valid bits and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (upd) vld_q[cov_q] <= 1'b1;
			if (upd) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

// ----- sv/trend_test_statistic_tracker.sv -----
// ----------------------------------------------------------------------------
// trend_test_statistic_tracker: running trend test statistics per covariate
// Top level: front end, queue, arithmetic back end.
// ----------------------------------------------------------------------------
// Each accepted sample gives one result word: the scaled deviation from the
// linear trend and the updated running maxima and integral of its covariate.
// The front end takes a sample every cycle while the two-entry queue has room
// and registers it before the queue; the back end works one word at a time,
// and that sets the rate: it picks up the word, takes the square root of the
// variance and does the standardized divide, takes the square root of the
// trend variance and divides for the weighted in-window deviation, runs the
// integral multiply and its weighted divide, and hands the word to the output
// register; the divides and the integral steps run only where the word needs
// them. A stalled output word holds the back end in its update state.
// Statistics start at zero after reset through per-entry valid bits.
module trend_test_statistic_tracker #(
	parameter int COVARIATES = tts_pkg::COVARIATES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [10:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         covariate_index,
	input  logic [9:0]         step_index,
	input  logic               restart,
	input  logic signed [31:0] cumulative_value,
	input  logic signed [31:0] final_value,
	input  logic [31:0]        variance,
	input  logic [31:0]        trend_variance,
	input  logic [16:0]        time_fraction,
	input  logic [31:0]        step_width,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] deviation,
	output logic [31:0]        sup_standardized,
	output logic [31:0]        sup_deviation,
	output logic [47:0]        integral_deviation
);
	localparam int CW = (COVARIATES > 1) ? $clog2(COVARIATES) : 1;
	localparam int QW = $bits(tts_pkg::tts_item_t) + CW;

	tts_pkg::tts_item_t f_item, b_item;
	logic [CW-1:0]      f_cov, b_cov;
	logic               push, q_full, pop, q_nonempty;
	logic [QW-1:0]      q_rdata;

	tts_front #(.COVARIATES(COVARIATES), .CW(CW)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .covariate_index, .step_index, .restart,
		.cumulative_value, .final_value, .variance, .trend_variance,
		.time_fraction, .step_width,
		.push, .q_full, .item(f_item), .cov(f_cov)
	);

	tts_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .wr(push), .wdata({f_cov, f_item}), .full(q_full),
		.rd(pop), .nonempty(q_nonempty), .rdata(q_rdata)
	);

	assign b_item = q_rdata[QW-CW-1:0];
	assign b_cov  = q_rdata[QW-1:QW-CW];

	tts_back #(.COVARIATES(COVARIATES), .CW(CW)) u_back (
		.clk, .arst_n, .q_nonempty, .pop, .q_item(b_item), .q_cov(b_cov),
		.out_valid, .out_ready, .deviation, .sup_standardized,
		.sup_deviation, .integral_deviation
	);

endmodule

// ----- sv/tts_checker.sv -----
// ----------------------------------------------------------------------------
// tts_checker: port-level checks of the tracker
// Watches the handshakes and result words; bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] deviation,
	input logic [31:0]        sup_deviation,
	input logic [47:0]        integral_deviation
);
	logic [3:0]  pend_q;
	logic [31:0] adev;

	assign adev = deviation[31] ? (~deviation + 32'sd1) : deviation;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 4'd0;
		else pend_q <= pend_q + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(deviation)
		&& $stable(integral_deviation))
		else $error("stalled result word changed");

	// every result word stems from an accepted sample
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result word without sample");

	// running max covers the current deviation
	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sup_deviation >= adev)
		else $error("sup_deviation below current deviation");

	// at most queue, front stage and back end hold words
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd5)
		else $error("too many words in flight");

endmodule

bind trend_test_statistic_tracker tts_checker u_tts_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.deviation, .sup_deviation, .integral_deviation
);
